[rtl/jac_pkg.sv]
// ----------------------------------------------------------------------------
// jac_pkg: shared types and constants of the joystick axis conditioner
// Register map, lane result and output beat layouts, and pipeline depths.
// ----------------------------------------------------------------------------
package jac_pkg;

	localparam int ADC_BITS_DEF = 12;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam int DEAD_BITS = 11;
	localparam int HAT_BITS = 15;
	localparam int AXIS_BITS = 16;
	localparam int REPORT_BITS = 8;
	localparam int HAT_DIR_BITS = 4;

	// Quotient bits of the per-lane divider; the axis magnitude never exceeds them.
	localparam int AXIS_QBITS = 15;
	localparam int REP_SHIFT = 7;
	localparam int REP_NW = AXIS_BITS + REP_SHIFT;

	localparam logic [AXIS_BITS-1:0] AXIS_FULL = 16'd32767;
	localparam logic [REPORT_BITS-1:0] REPORT_FULL = 8'd127;

	localparam logic [DEAD_BITS-1:0] DEAD_RST = 11'd100;
	localparam logic [HAT_BITS-1:0] HAT_RST = 15'd16384;

	// Lane registers: four setup stages, the divider, three finishing stages.
	localparam int LANE_LAT = 4 + AXIS_QBITS + 3;

	localparam int OUT_TDATA_W = 56;

	typedef enum logic [2:0] {
		RI_JOY_MIN   = 3'd0,
		RI_JOY_MAX   = 3'd1,
		RI_CENTER_X  = 3'd2,
		RI_CENTER_Y  = 3'd3,
		RI_DEAD      = 3'd4,
		RI_HAT_THR   = 3'd5,
		RI_INVERT_Y  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		REG_MID  = 2'd0,
		REG_LOW  = 2'd1,
		REG_HIGH = 2'd2
	} region_t;

	typedef enum logic [HAT_DIR_BITS-1:0] {
		DIR_CENTER = 4'd0,
		DIR_UP     = 4'd1,
		DIR_UP_RT  = 4'd2,
		DIR_RT     = 4'd3,
		DIR_DN_RT  = 4'd4,
		DIR_DN     = 4'd5,
		DIR_DN_LT  = 4'd6,
		DIR_LT     = 4'd7,
		DIR_UP_LT  = 4'd8
	} hat_t;

	typedef struct packed {
		region_t region;
		logic    zero;
		logic    sat;
		logic    neg;
	} div_tag_t;

	typedef struct packed {
		logic signed [AXIS_BITS-1:0]   axis;
		logic signed [REPORT_BITS-1:0] report;
	} lane_res_t;

	typedef struct packed {
		logic [3:0]                    pad;
		logic signed [REPORT_BITS-1:0] report_y;
		logic signed [REPORT_BITS-1:0] report_x;
		logic [HAT_DIR_BITS-1:0]       hat_dir;
		logic signed [AXIS_BITS-1:0]   axis_y;
		logic signed [AXIS_BITS-1:0]   axis_x;
	} out_item_t;

endpackage

[rtl/jac_regs.sv]
// ----------------------------------------------------------------------------
// jac_regs: configuration register file
// APB-style write and read access to the calibration and hat settings.
// ----------------------------------------------------------------------------
module jac_regs #(
	parameter int ADC_BITS = jac_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jac_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [jac_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [jac_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [ADC_BITS-1:0]             joy_min,
	output logic [ADC_BITS-1:0]             joy_max,
	output logic [ADC_BITS-1:0]             center_x,
	output logic [ADC_BITS-1:0]             center_y,
	output logic [jac_pkg::DEAD_BITS-1:0]   dead_width,
	output logic [jac_pkg::HAT_BITS-1:0]    hat_thr,
	output logic                            invert_y
);

	localparam logic [ADC_BITS-1:0] ADC_ONES = '1;
	localparam logic [ADC_BITS-1:0] ADC_MID = {1'b1, {(ADC_BITS-1){1'b0}}};

	logic [ADC_BITS-1:0]           joy_min_q;
	logic [ADC_BITS-1:0]           joy_max_q;
	logic [ADC_BITS-1:0]           center_x_q;
	logic [ADC_BITS-1:0]           center_y_q;
	logic [jac_pkg::DEAD_BITS-1:0] dead_q;
	logic [jac_pkg::HAT_BITS-1:0]  hat_thr_q;
	logic                          invert_y_q;
	logic                          wr_en;
	jac_pkg::reg_idx_t             idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign idx = jac_pkg::reg_idx_t'(paddr[jac_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_min_q <= '0;
			joy_max_q <= ADC_ONES;
			center_x_q <= ADC_MID;
			center_y_q <= ADC_MID;
			dead_q <= jac_pkg::DEAD_RST;
			hat_thr_q <= jac_pkg::HAT_RST;
			invert_y_q <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				jac_pkg::RI_JOY_MIN: begin
					joy_min_q <= pwdata[ADC_BITS-1:0];
				end
				jac_pkg::RI_JOY_MAX: begin
					joy_max_q <= pwdata[ADC_BITS-1:0];
				end
				jac_pkg::RI_CENTER_X: begin
					center_x_q <= pwdata[ADC_BITS-1:0];
				end
				jac_pkg::RI_CENTER_Y: begin
					center_y_q <= pwdata[ADC_BITS-1:0];
				end
				jac_pkg::RI_DEAD: begin
					dead_q <= pwdata[jac_pkg::DEAD_BITS-1:0];
				end
				jac_pkg::RI_HAT_THR: begin
					hat_thr_q <= pwdata[jac_pkg::HAT_BITS-1:0];
				end
				jac_pkg::RI_INVERT_Y: begin
					invert_y_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			jac_pkg::RI_JOY_MIN:  prdata = jac_pkg::APB_DATA_W'(joy_min_q);
			jac_pkg::RI_JOY_MAX:  prdata = jac_pkg::APB_DATA_W'(joy_max_q);
			jac_pkg::RI_CENTER_X: prdata = jac_pkg::APB_DATA_W'(center_x_q);
			jac_pkg::RI_CENTER_Y: prdata = jac_pkg::APB_DATA_W'(center_y_q);
			jac_pkg::RI_DEAD:     prdata = jac_pkg::APB_DATA_W'(dead_q);
			jac_pkg::RI_HAT_THR:  prdata = jac_pkg::APB_DATA_W'(hat_thr_q);
			jac_pkg::RI_INVERT_Y: prdata = jac_pkg::APB_DATA_W'(invert_y_q);
			default:              prdata = '0;
		endcase
	end

	assign joy_min = joy_min_q;
	assign joy_max = joy_max_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign dead_width = dead_q;
	assign hat_thr = hat_thr_q;
	assign invert_y = invert_y_q;

endmodule

[rtl/jac_lane.sv]
// ----------------------------------------------------------------------------
// jac_lane: one axis of the conditioner
// Deadzone mapping through a one-bit-per-stage divider, then report rescale.
// ----------------------------------------------------------------------------
module jac_lane #(
	parameter int ADC_BITS = jac_pkg::ADC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          ce,
	input  logic [ADC_BITS-1:0]           raw,
	input  logic [ADC_BITS-1:0]           centre,
	input  logic [ADC_BITS-1:0]           joy_min,
	input  logic [ADC_BITS-1:0]           joy_max,
	input  logic [jac_pkg::DEAD_BITS-1:0] dead_width,
	output jac_pkg::lane_res_t            res
);

	localparam int QB = jac_pkg::AXIS_QBITS;
	localparam int MB = (ADC_BITS > jac_pkg::DEAD_BITS) ? ADC_BITS : jac_pkg::DEAD_BITS;
	localparam int SW = MB + 2;
	localparam int MAGW = MB + 1;
	localparam int NW = ADC_BITS + QB;
	localparam int CW = (NW > MAGW + QB) ? NW : MAGW + QB;
	localparam int RN = jac_pkg::REP_NW;
	localparam int AB = jac_pkg::AXIS_BITS;
	localparam int RB = jac_pkg::REPORT_BITS;

	// Setup stages.
	logic [ADC_BITS-1:0]   raw_s1;
	logic signed [SW-1:0]  lo_s1;
	logic signed [SW-1:0]  hi_s1;
	jac_pkg::region_t      region_s2;
	logic signed [SW-1:0]  span_s2;
	logic signed [SW-1:0]  diff_s2;
	jac_pkg::region_t      region_s3;
	logic [NW-1:0]         num_s3;
	logic [MAGW-1:0]       span_mag_s3;
	logic                  zero_s3;
	logic                  neg_s3;

	logic signed [SW-1:0]  raw_e;
	logic signed [SW-1:0]  jmin_e;
	logic signed [SW-1:0]  jmax_e;
	logic                  is_low;
	logic                  is_high;
	logic                  span_neg;
	logic                  diff_neg;
	logic [MAGW-1:0]       span_mag;
	logic [ADC_BITS-1:0]   diff_mag;

	// Divider stages: index 0 is loaded by the fourth setup stage.
	logic [NW-1:0]         rem_s [0:QB];
	logic [MAGW-1:0]       den_s [0:QB];
	logic [QB-1:0]         quo_s [0:QB];
	jac_pkg::div_tag_t     tag_s [0:QB];

	// Finishing stages.
	logic signed [AB-1:0]  axis_s5;
	logic [AB-1:0]         u_s5;
	logic signed [AB-1:0]  axis_s6;
	logic [RN-1:0]         n_s6;
	jac_pkg::lane_res_t    res_s7;

	logic [QB-1:0]         qs;
	logic signed [AB-1:0]  axis_d;
	logic [AB-1:0]         u_d;
	logic [RB-1:0]         q0;
	logic [AB-1:0]         rem_rep;
	logic [RB-1:0]         q_rep;

	always_ff @(posedge clk) begin
		if (ce) begin
			raw_s1 <= raw;
			lo_s1 <= $signed(SW'(centre)) - $signed(SW'(dead_width));
			hi_s1 <= $signed(SW'(centre)) + $signed(SW'(dead_width));
		end
	end

	assign raw_e = $signed(SW'(raw_s1));
	assign jmin_e = $signed(SW'(joy_min));
	assign jmax_e = $signed(SW'(joy_max));
	assign is_low = raw_e < lo_s1;
	assign is_high = raw_e > hi_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			if (is_low) begin
				region_s2 <= jac_pkg::REG_LOW;
				span_s2 <= lo_s1 - jmin_e;
				diff_s2 <= raw_e - jmin_e;
			end else begin
				region_s2 <= is_high ? jac_pkg::REG_HIGH : jac_pkg::REG_MID;
				span_s2 <= jmax_e - hi_s1;
				diff_s2 <= raw_e - hi_s1;
			end
		end
	end

	assign span_neg = span_s2[SW-1];
	assign diff_neg = diff_s2[SW-1];
	assign span_mag = MAGW'(span_neg ? -span_s2 : span_s2);
	assign diff_mag = ADC_BITS'(diff_neg ? -diff_s2 : diff_s2);

	always_ff @(posedge clk) begin
		if (ce) begin
			region_s3 <= region_s2;
			num_s3 <= (NW'(diff_mag) << QB) - NW'(diff_mag);
			span_mag_s3 <= span_mag;
			zero_s3 <= (span_s2 == '0);
			neg_s3 <= span_neg ^ diff_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= num_s3;
			den_s[0] <= span_mag_s3;
			quo_s[0] <= '0;
			tag_s[0].region <= region_s3;
			tag_s[0].zero <= zero_s3;
			tag_s[0].neg <= neg_s3;
			tag_s[0].sat <= CW'(num_s3) >= (CW'(span_mag_s3) << QB);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [CW-1:0] trial;
		logic          ge;

		assign trial = CW'(den_s[k]) << (QB - 1 - k);
		assign ge = CW'(rem_s[k]) >= trial;

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1] <= ge ? NW'(CW'(rem_s[k]) - trial) : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	always_comb begin
		if (tag_s[QB].zero) begin
			qs = (tag_s[QB].region == jac_pkg::REG_HIGH) ? '1 : '0;
		end else if (tag_s[QB].neg) begin
			qs = '0;
		end else if (tag_s[QB].sat) begin
			qs = '1;
		end else begin
			qs = quo_s[QB];
		end
		case (tag_s[QB].region)
			jac_pkg::REG_LOW: begin
				axis_d = $signed(AB'(qs)) - $signed(jac_pkg::AXIS_FULL);
				u_d = AB'(qs);
			end
			jac_pkg::REG_HIGH: begin
				axis_d = $signed(AB'(qs));
				u_d = AB'(qs) + jac_pkg::AXIS_FULL;
			end
			default: begin
				axis_d = '0;
				u_d = jac_pkg::AXIS_FULL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			axis_s5 <= axis_d;
			u_s5 <= u_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			axis_s6 <= axis_s5;
			n_s6 <= (RN'(u_s5) << jac_pkg::REP_SHIFT) - RN'(u_s5);
		end
	end

	// The quotient by 32767 is the shift by 15 or one more.
	assign q0 = n_s6[RN-1:QB];
	assign rem_rep = AB'(n_s6[QB-1:0]) + AB'(q0);
	assign q_rep = q0 + RB'(rem_rep >= jac_pkg::AXIS_FULL);

	always_ff @(posedge clk) begin
		if (ce) begin
			res_s7.axis <= axis_s6;
			res_s7.report <= $signed(q_rep - jac_pkg::REPORT_FULL);
		end
	end

	assign res = res_s7;

endmodule

[rtl/jac_merge.sv]
// ----------------------------------------------------------------------------
// jac_merge: hat decision and output stage
// Combines both lanes into one beat, with an output register and a skid entry.
// ----------------------------------------------------------------------------
module jac_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  jac_pkg::lane_res_t               res_x,
	input  jac_pkg::lane_res_t               res_y,
	input  logic [jac_pkg::HAT_BITS-1:0]     hat_thr,
	input  logic                             invert_y,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	// Fields from bit 0: axis_x, axis_y, hat_dir, report_x, report_y, zero fill.
	output logic [jac_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             adv
);

	localparam int TW = jac_pkg::HAT_BITS + 2;

	logic                  out_vld_q;
	logic                  skid_vld_q;
	jac_pkg::out_item_t    out_q;
	jac_pkg::out_item_t    skid_q;
	jac_pkg::out_item_t    item;
	jac_pkg::hat_t         hat;
	logic signed [TW-1:0]  t_pos;
	logic signed [TW-1:0]  t_neg;
	logic                  y_pos;
	logic                  y_neg;
	logic                  up;
	logic                  down;
	logic                  right;
	logic                  left;
	logic                  pop;

	assign t_pos = $signed(TW'(hat_thr));
	assign t_neg = -t_pos;
	assign right = res_x.axis > t_pos;
	assign left = res_x.axis < t_neg;
	assign y_pos = res_y.axis > t_pos;
	assign y_neg = res_y.axis < t_neg;
	assign up = invert_y ? y_neg : y_pos;
	assign down = invert_y ? y_pos : y_neg;

	always_comb begin
		if (up && right) begin
			hat = jac_pkg::DIR_UP_RT;
		end else if (up && left) begin
			hat = jac_pkg::DIR_UP_LT;
		end else if (down && right) begin
			hat = jac_pkg::DIR_DN_RT;
		end else if (down && left) begin
			hat = jac_pkg::DIR_DN_LT;
		end else if (up) begin
			hat = jac_pkg::DIR_UP;
		end else if (down) begin
			hat = jac_pkg::DIR_DN;
		end else if (right) begin
			hat = jac_pkg::DIR_RT;
		end else if (left) begin
			hat = jac_pkg::DIR_LT;
		end else begin
			hat = jac_pkg::DIR_CENTER;
		end
	end

	always_comb begin
		item.pad = '0;
		item.axis_x = res_x.axis;
		item.axis_y = res_y.axis;
		item.hat_dir = hat;
		item.report_x = res_x.report;
		item.report_y = res_y.report;
	end

	assign pop = out_vld_q & m_tready;
	assign adv = ~skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!out_vld_q || pop) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_vld_q || pop) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (!out_vld_q || pop) begin
				out_q <= item;
			end else begin
				skid_q <= item;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_q;

endmodule

[rtl/joystick_axis_conditioner.sv]
// Throughput: one beat per cycle while s_tready is high; each axis lane holds
// a 15-stage divider that retires one quotient bit per stage, so no stage is
// used twice for a beat. A beat passes the lane stages and the merge register.
// Reset: arst_n clears the pipeline and output valid flags at once and loads
// every configuration register with its default; no clearing pass is needed.
// ----------------------------------------------------------------------------
// joystick_axis_conditioner: top level
// Two axis lanes in parallel, a merging stage for the hat, and the register file.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner #(
	parameter int ADC_BITS = jac_pkg::ADC_BITS_DEF,
	localparam int S_TDATA_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: raw_x, raw_y, zero fill.
	input  logic [S_TDATA_W-1:0]            s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: axis_x, axis_y, hat_dir, report_x, report_y, zero fill.
	output logic [jac_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jac_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [jac_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [jac_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int LAT = jac_pkg::LANE_LAT;

	logic [ADC_BITS-1:0]           joy_min;
	logic [ADC_BITS-1:0]           joy_max;
	logic [ADC_BITS-1:0]           center_x;
	logic [ADC_BITS-1:0]           center_y;
	logic [jac_pkg::DEAD_BITS-1:0] dead_width;
	logic [jac_pkg::HAT_BITS-1:0]  hat_thr;
	logic                          invert_y;
	logic                          adv;
	logic [LAT-1:0]                valid_s;
	jac_pkg::lane_res_t            res_x;
	jac_pkg::lane_res_t            res_y;

	jac_regs #(
		.ADC_BITS (ADC_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.joy_min    (joy_min),
		.joy_max    (joy_max),
		.center_x   (center_x),
		.center_y   (center_y),
		.dead_width (dead_width),
		.hat_thr    (hat_thr),
		.invert_y   (invert_y)
	);

	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[LAT-2:0], s_tvalid};
		end
	end

	jac_lane #(
		.ADC_BITS (ADC_BITS)
	) u_lane_x (
		.clk        (clk),
		.ce         (adv),
		.raw        (s_tdata[ADC_BITS-1:0]),
		.centre     (center_x),
		.joy_min    (joy_min),
		.joy_max    (joy_max),
		.dead_width (dead_width),
		.res        (res_x)
	);

	jac_lane #(
		.ADC_BITS (ADC_BITS)
	) u_lane_y (
		.clk        (clk),
		.ce         (adv),
		.raw        (s_tdata[2*ADC_BITS-1:ADC_BITS]),
		.centre     (center_y),
		.joy_min    (joy_min),
		.joy_max    (joy_max),
		.dead_width (dead_width),
		.res        (res_y)
	);

	jac_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s[LAT-1] & adv),
		.res_x    (res_x),
		.res_y    (res_y),
		.hat_thr  (hat_thr),
		.invert_y (invert_y),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.adv      (adv)
	);

endmodule

[test/tb_joystick_axis_conditioner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_axis_conditioner: self-checking bench for the joystick conditioner
// Streams raw X/Y sample pairs through the block under several register settings,
// predicts each result beat in the bench, and compares it field by field.
// ----------------------------------------------------------------------------
module tb_joystick_axis_conditioner;
	import jac_pkg::*;

	localparam int N_SETTINGS = 8;
	localparam int RANDOM_PER_SETTING = 150;
	localparam int UNMAPPED_IDX = 7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint FULL_SCALE = 32767;
	localparam int N_EDGE = 16;
	localparam logic [11:0] EDGE_X [N_EDGE] = '{12'd2048, 12'd4095, 12'd0, 12'd2048,
		12'd2048, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1948, 12'd1947, 12'd2148,
		12'd2149, 12'hAAA, 12'h555, 12'd1};
	localparam logic [11:0] EDGE_Y [N_EDGE] = '{12'd2048, 12'd2048, 12'd2048, 12'd4095,
		12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd2148, 12'd2149, 12'd1948,
		12'd1947, 12'h555, 12'hAAA, 12'd4094};

	class axis_tracker;
		int lo_stop = 0;
		int hi_stop = 4095;
		int rest_x = 2048;
		int rest_y = 2048;
		int dead_half = 100;
		int hat_thr = 16384;
		int flip_y = 0;
		out_item_t expected_q[$];
		int errors = 0;
		int samples_seen = 0;
		int results_seen = 0;

		function void log_mismatch(string msg);
			errors++;
			if (errors <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void set_reg(int idx, logic [31:0] v);
			case (idx)
				RI_JOY_MIN: lo_stop = int'(v[11:0]);
				RI_JOY_MAX: hi_stop = int'(v[11:0]);
				RI_CENTER_X: rest_x = int'(v[11:0]);
				RI_CENTER_Y: rest_y = int'(v[11:0]);
				RI_DEAD: dead_half = int'(v[10:0]);
				RI_HAT_THR: hat_thr = int'(v[14:0]);
				RI_INVERT_Y: flip_y = int'(v[0]);
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_word(int idx);
			case (idx)
				RI_JOY_MIN: return lo_stop;
				RI_JOY_MAX: return hi_stop;
				RI_CENTER_X: return rest_x;
				RI_CENTER_Y: return rest_y;
				RI_DEAD: return dead_half;
				RI_HAT_THR: return hat_thr;
				default: return flip_y;
			endcase
		endfunction

		function longint deflection(longint raw, longint rest);
			longint lo;
			longint hi;
			longint span;
			longint v;
			lo = rest - dead_half;
			hi = rest + dead_half;
			if (raw < lo) begin
				span = lo - lo_stop;
				if (span == 0)
					return -FULL_SCALE;
				v = (raw - lo_stop) * FULL_SCALE / span - FULL_SCALE;
				if (v < -FULL_SCALE)
					v = -FULL_SCALE;
				if (v > 0)
					v = 0;
				return v;
			end
			if (raw > hi) begin
				span = hi_stop - hi;
				if (span == 0)
					return FULL_SCALE;
				v = (raw - hi) * FULL_SCALE / span;
				if (v < 0)
					v = 0;
				if (v > FULL_SCALE)
					v = FULL_SCALE;
				return v;
			end
			return 0;
		endfunction

		function void note_sample(logic [11:0] raw_x, logic [11:0] raw_y);
			out_item_t want;
			longint ax;
			longint ay;
			longint hy;
			longint t;
			bit up;
			bit down;
			bit right;
			bit left;
			hat_t dir;
			ax = deflection(raw_x, rest_x);
			ay = deflection(raw_y, rest_y);
			hy = flip_y ? -ay : ay;
			t = hat_thr;
			up = hy > t;
			down = hy < -t;
			right = ax > t;
			left = ax < -t;
			if (up && right) dir = DIR_UP_RT;
			else if (up && left) dir = DIR_UP_LT;
			else if (down && right) dir = DIR_DN_RT;
			else if (down && left) dir = DIR_DN_LT;
			else if (up) dir = DIR_UP;
			else if (down) dir = DIR_DN;
			else if (right) dir = DIR_RT;
			else if (left) dir = DIR_LT;
			else dir = DIR_CENTER;
			want = '0;
			want.axis_x = ax[15:0];
			want.axis_y = ay[15:0];
			want.hat_dir = dir;
			want.report_x = 8'((ax + FULL_SCALE) * 254 / 65534 - 127);
			want.report_y = 8'((ay + FULL_SCALE) * 254 / 65534 - 127);
			expected_q.push_back(want);
			samples_seen++;
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] word);
			out_item_t got;
			out_item_t want;
			got = out_item_t'(word);
			results_seen++;
			if (expected_q.size() == 0) begin
				log_mismatch($sformatf("result beat %h arrived with nothing expected", word));
				return;
			end
			want = expected_q.pop_front();
			if (got.axis_x !== want.axis_x || got.axis_y !== want.axis_y ||
					got.hat_dir !== want.hat_dir || got.report_x !== want.report_x ||
					got.report_y !== want.report_y)
				log_mismatch($sformatf(
					"beat %0d: expected x=%0d y=%0d hat=%0d rx=%0d ry=%0d, got x=%0d y=%0d hat=%0d rx=%0d ry=%0d",
					results_seen, want.axis_x, want.axis_y, want.hat_dir, want.report_x,
					want.report_y, got.axis_x, got.axis_y, got.hat_dir, got.report_x,
					got.report_y));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// Fields from bit 0: raw_x, raw_y.
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// Fields from bit 0: axis_x, axis_y, hat_dir, report_x, report_y, zero fill.
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	axis_tracker sb = new();
	bit calm = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	joystick_axis_conditioner dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Most samples sit near the deadzone edges and the end stops of the current setting.
	function automatic logic [11:0] pick_raw(int rest);
		int base;
		case ($urandom_range(0, 4))
			0, 1: return 12'($urandom_range(0, 4095));
			2: base = rest - sb.dead_half;
			3: base = rest + sb.dead_half;
			default: base = $urandom_range(0, 1) ? sb.lo_stop : sb.hi_stop;
		endcase
		base = base + int'($urandom_range(0, 6)) - 3;
		if (base < 0)
			base = 0;
		if (base > 4095)
			base = 4095;
		return base[11:0];
	endfunction

	task automatic send_sample(input logic [11:0] raw_x, input logic [11:0] raw_y);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {raw_y, raw_x};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(raw_x, raw_y);
	endtask

	task automatic apb_write(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic read_back();
		for (int idx = RI_JOY_MIN; idx <= RI_INVERT_Y; idx++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= APB_ADDR_W'(idx * 4);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== sb.reg_word(idx))
				sb.log_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata,
					sb.reg_word(idx)));
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (LANE_LAT + 4) @(posedge clk);
	endtask

	task automatic apply_setting(input int p);
		case (p)
			1: begin
				// The X low span and the Y high span both collapse to zero width.
				apply_all(1000, 3000, 1100, 2900, 100, 0, 1);
			end
			2: begin
				apply_all(4095, 0, 0, 4095, 2047, 32767, 0);
				apb_write(UNMAPPED_IDX, 32'hFFFF_FFFF);
			end
			3: apply_all(0, 4095, 2048, 2048, 0, 1, 1);
			4: apply_all(3000, 1000, 2048, 2048, 50, 8000, 0);
			default: begin
				for (int idx = RI_JOY_MIN; idx <= RI_INVERT_Y; idx++)
					apb_write(idx, $urandom());
			end
		endcase
	endtask

	task automatic apply_all(input int lo, input int hi, input int cx, input int cy,
			input int dead, input int thr, input int inv);
		apb_write(RI_JOY_MIN, lo);
		apb_write(RI_JOY_MAX, hi);
		apb_write(RI_CENTER_X, cx);
		apb_write(RI_CENTER_Y, cy);
		apb_write(RI_DEAD, dead);
		apb_write(RI_HAT_THR, thr);
		apb_write(RI_INVERT_Y, inv);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				hold_left = pick_gap();
				if (hold_left > 0) begin
					m_tready <= 1'b0;
					hold_left--;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", sb.pending());
			$display("[joystick_axis_conditioner] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < N_SETTINGS; p++) begin
			if (p > 0)
				apply_setting(p);
			read_back();
			if (p == 0) begin
				for (int i = 0; i < N_EDGE; i++)
					send_sample(EDGE_X[i], EDGE_Y[i]);
			end
			for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
				if (i % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				send_sample(pick_raw(sb.rest_x), pick_raw(sb.rest_y));
			end
			s_tvalid <= 1'b0;
			calm = 1'b0;
			drain();
		end
		$display("Streamed %0d sample pairs over %0d register settings, including zero,",
			sb.samples_seen, N_SETTINGS);
		$display("inverted and extreme spans; %0d result beats checked, %0d mismatches.",
			sb.results_seen, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[joystick_axis_conditioner] OK");
		else
			$display("[joystick_axis_conditioner] ERROR");
		$finish;
	end

endmodule

[joystick_axis_conditioner.f]
rtl/jac_pkg.sv
rtl/jac_regs.sv
rtl/jac_lane.sv
rtl/jac_merge.sv
rtl/joystick_axis_conditioner.sv
test/tb_joystick_axis_conditioner.sv
